FILE: rtl/core/quintic_segment_coefficients_unit_macros.svh
// Assertion macros shared by the checker of the quintic segment coefficients unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUINTIC_SEGMENT_COEFFICIENTS_UNIT_MACROS_SVH
`define QUINTIC_SEGMENT_COEFFICIENTS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QSC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qsc: property violated");

// Next-cycle implication, disabled during reset.
`define QSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qsc: property violated");

`endif

FILE: rtl/core/qsc_pkg.sv
// Shared widths, codes and state type of the quintic segment coefficients unit.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps

package qsc_pkg;

    localparam int POS_W   = 32;
    localparam int TIME_W  = 24;
    localparam int COEF_W  = 48;
    localparam int TERM_W  = 40;
    localparam int NUM_W   = 96;
    localparam int DVD_W   = 152;
    localparam int SLOPE_W = 51;
    localparam int LIM_W   = 31;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] CFG_START_VEL = 3'd0;
    localparam logic [IDX_W-1:0] CFG_START_ACC = 3'd1;
    localparam logic [IDX_W-1:0] CFG_END_VEL   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_END_ACC   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_VEL_LIM   = 3'd4;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_FEW = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_S1_GO,
        ST_S1_WAIT,
        ST_S2_GO,
        ST_S2_WAIT,
        ST_MEAN,
        ST_M1_GO,
        ST_M1_WAIT,
        ST_M2_GO,
        ST_M2_WAIT,
        ST_D_GO,
        ST_D_WAIT,
        ST_C_STORE,
        ST_PUSH
    } state_t;

endpackage

FILE: rtl/core/qsc_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
// One multiplier bit per cycle; depends on qsc_pkg.
`timescale 1ns / 1ps

module qsc_serial_mul
    import qsc_pkg::*;
#(
    parameter int NW = NUM_W,
    parameter int TW = TIME_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] multiplicand,
    input  logic [TW-1:0] multiplier,
    output logic          done,
    output logic [NW-1:0] product
);

    localparam int CW = $clog2(TW + 1);

    logic [NW-1:0] acc_reg;
    logic [NW-1:0] m_reg;
    logic [TW-1:0] t_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(TW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            m_reg   <= multiplicand;
            t_reg   <= multiplier;
        end
        else if (busy_reg)
        begin
            if (t_reg[0])
            begin
                acc_reg <= acc_reg + m_reg;
            end
            m_reg <= m_reg << 1;
            t_reg <= t_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/core/qsc_serial_div.sv
// Bit-serial restoring divider of a wide unsigned dividend by a narrow divisor.
// One quotient bit per cycle, truncating; depends on qsc_pkg.
`timescale 1ns / 1ps

module qsc_serial_div
    import qsc_pkg::*;
#(
    parameter int DW = DVD_W,
    parameter int TW = TIME_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [TW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [TW-1:0] rem_reg;
    logic [TW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [TW:0]   trial;
    logic [TW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, q_reg[DW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[TW-1:0] : trial[TW-1:0];
            q_reg   <= {q_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/core/quintic_segment_coefficients_unit.sv
// Top level of the quintic segment coefficients unit: sequencer, state and result register.
// Depends on qsc_pkg, qsc_serial_mul and qsc_serial_div.
//
// Waypoints enter as beats on the s_axis channel (position, segment time, tlast for the
// final waypoint); each finished segment leaves as one beat on m_axis carrying c0..c5,
// the duration, tlast for the path's final segment and the status in tuser.
// Registers are written through cfg_we, cfg_index and cfg_data; the user is to write them
// only while the unit is idle, which the unit itself does not enforce. One waypoint is
// worked on at a time; s_axis_tready is high only when no work is open. A waypoint that
// only fills the history passes through ST_DECIDE and back to ST_IDLE. An inner waypoint
// costs two slope divisions and one segment; the last one may add a second segment.
// Each segment's time is set by the bit-serial divider: c3, c4 and c5 need three, four and
// five passes through it, one quotient bit per cycle over a 152-bit dividend, and by two
// multiplies per term. A finished segment waits in the output register, so the next
// segment or waypoint is worked on while the receiver stalls; the unit only holds when a
// further result is ready while the output register is still full.
// Reset clears the path history, the register file (velocity limit to its maximum) and
// the output valid flag.
`timescale 1ns / 1ps

module quintic_segment_coefficients_unit
    import qsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [55:0]        s_axis_tdata,   // position [31:0], segment_time [55:32]
    input  logic               s_axis_tlast,   // is_last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [311:0]       m_axis_tdata,   // coef_0..coef_5 (48 bits each), duration
    output logic               m_axis_tlast,   // final_segment
    output logic [1:0]         m_axis_tuser,   // status
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [POS_W-1:0]   cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic signed [POS_W-1:0]   sv_reg, sa_reg, ev_reg, ea_reg;
    logic [LIM_W-1:0]          lim_reg;

    logic signed [POS_W-1:0]   pin_reg;
    logic [TIME_W-1:0]         tr_reg;
    logic                      last_reg;

    logic signed [POS_W-1:0]   older_reg, newer_reg, pvel_reg;
    logic [TIME_W-1:0]         pdur_reg;
    logic [1:0]                ps_reg;
    logic                      first_reg;

    logic signed [POS_W-1:0]   e_p0_reg, e_pf_reg, e_v0_reg, e_a0_reg, e_vf_reg, e_af_reg;
    logic [TIME_W-1:0]         e_tr_reg;
    logic                      e_fin_reg;
    logic                      err_reg;
    logic                      sat_reg;
    logic                      second_reg;
    logic [1:0]                idx_reg;
    logic [2:0]                dcnt_reg;
    logic [COEF_W-1:0]         cf_reg [3];
    logic [DVD_W-1:0]          num_reg;
    logic [TIME_W-1:0]         den_reg;
    logic                      neg_reg;
    logic signed [SLOPE_W-1:0] s1_reg;
    logic signed [POS_W-1:0]   v_reg;

    logic                      ov_reg;
    logic [311:0]              odata_reg;
    logic                      olast_reg;
    logic [1:0]                ouser_reg;

    logic                      mul_start, mul_done, div_start, div_done;
    logic [NUM_W-1:0]          mul_m, mul_p;
    logic [DVD_W-1:0]          div_q;
    logic                      out_free, load_out, in_ready;

    logic [TIME_W-1:0]         tr_in;
    logic signed [5:0]         kh, kvf, kv0, ka0, kaf;
    logic signed [TERM_W-1:0]  hx, term_a, term_b, term_c;
    logic signed [NUM_W-1:0]   n_full;
    logic [NUM_W-1:0]          nmag;
    logic [5:0]                sh;
    logic [DVD_W-1:0]          nshift;
    logic [2:0]                kdiv;
    logic                      pos_sat, neg_sat, c_sat;
    logic [COEF_W-1:0]         c_val;
    logic signed [POS_W:0]     d1, d2;
    logic [POS_W:0]            d1_mag, d2_mag;
    logic signed [SLOPE_W-1:0] s2_val, s_sum, s_adj, s_half, lim_s, v_clamp;
    logic [COEF_W-1:0]         c0, c1, c2;

    assign tr_in = (s_axis_tdata[55:32] == '0) ? TIME_W'(1) : s_axis_tdata[55:32];

    always_comb
    begin
        case (idx_reg)
            2'd0:    begin kh = 6'sd20;  kvf = -6'sd8;  kv0 = -6'sd12; ka0 = -6'sd3; kaf = 6'sd1;  end
            2'd1:    begin kh = -6'sd30; kvf = 6'sd14;  kv0 = 6'sd16;  ka0 = 6'sd3;  kaf = -6'sd2; end
            default: begin kh = 6'sd12;  kvf = -6'sd6;  kv0 = -6'sd6;  ka0 = -6'sd1; kaf = 6'sd1;  end
        endcase
        case (idx_reg)
            2'd0:    begin sh = 6'd31; kdiv = 3'd3; end
            2'd1:    begin sh = 6'd47; kdiv = 3'd4; end
            default: begin sh = 6'd63; kdiv = 3'd5; end
        endcase
    end

    assign hx     = TERM_W'(e_pf_reg) - TERM_W'(e_p0_reg);
    assign term_a = TERM_W'(e_a0_reg) * ka0 + TERM_W'(e_af_reg) * kaf;
    assign term_b = TERM_W'(e_vf_reg) * kvf + TERM_W'(e_v0_reg) * kv0;
    assign term_c = hx * kh;

    assign mul_m  = (state_reg == ST_M1_GO) ? NUM_W'(term_a)
                                            : mul_p + (NUM_W'(term_b) <<< 16);
    assign n_full = $signed(mul_p + (NUM_W'(term_c) <<< 32));
    assign nmag   = n_full[NUM_W-1] ? NUM_W'(-n_full) : NUM_W'(n_full);
    assign nshift = {{(DVD_W - NUM_W){1'b0}}, nmag} << sh;

    assign pos_sat = |num_reg[DVD_W-1:COEF_W-1];
    assign neg_sat = (|num_reg[DVD_W-1:COEF_W]) ||
                     (num_reg[COEF_W-1] && (|num_reg[COEF_W-2:0]));
    assign c_sat   = neg_reg ? neg_sat : pos_sat;
    always_comb
    begin
        if (neg_reg)
        begin
            c_val = neg_sat ? {1'b1, {(COEF_W-1){1'b0}}} : -num_reg[COEF_W-1:0];
        end
        else
        begin
            c_val = pos_sat ? {1'b0, {(COEF_W-1){1'b1}}} : num_reg[COEF_W-1:0];
        end
    end

    assign d1     = {newer_reg[POS_W-1], newer_reg} - {older_reg[POS_W-1], older_reg};
    assign d2     = {pin_reg[POS_W-1], pin_reg} - {newer_reg[POS_W-1], newer_reg};
    assign d1_mag = d1[POS_W] ? (POS_W+1)'(-d1) : (POS_W+1)'(d1);
    assign d2_mag = d2[POS_W] ? (POS_W+1)'(-d2) : (POS_W+1)'(d2);

    assign s2_val = neg_reg ? -$signed({2'b00, div_q[48:0]}) : $signed({2'b00, div_q[48:0]});
    assign s_sum  = s1_reg + s2_val;
    assign s_adj  = s_sum + SLOPE_W'(s_sum[SLOPE_W-1]);
    assign s_half = s_adj >>> 1;
    assign lim_s  = $signed({{(SLOPE_W-LIM_W){1'b0}}, lim_reg});
    always_comb
    begin
        if (s_half > lim_s)
        begin
            v_clamp = lim_s;
        end
        else if (s_half < -lim_s)
        begin
            v_clamp = -lim_s;
        end
        else
        begin
            v_clamp = s_half;
        end
    end

    assign c0 = {e_p0_reg, 16'b0};
    assign c1 = {e_v0_reg, 16'b0};
    assign c2 = {e_a0_reg[POS_W-1], e_a0_reg, 15'b0};

    assign out_free = !ov_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_axis_tvalid) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                case (ps_reg)
                    2'd0:    state_next = last_reg ? ST_PUSH : ST_IDLE;
                    2'd1:    state_next = last_reg ? ST_M1_GO : ST_IDLE;
                    2'd2:    state_next = ST_S1_GO;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_S1_GO:   state_next = ST_S1_WAIT;
            ST_S1_WAIT: if (div_done) state_next = ST_S2_GO;
            ST_S2_GO:   state_next = ST_S2_WAIT;
            ST_S2_WAIT: if (div_done) state_next = ST_MEAN;
            ST_MEAN:    state_next = ST_M1_GO;
            ST_M1_GO:   state_next = ST_M1_WAIT;
            ST_M1_WAIT: if (mul_done) state_next = ST_M2_GO;
            ST_M2_GO:   state_next = ST_M2_WAIT;
            ST_M2_WAIT: if (mul_done) state_next = ST_D_GO;
            ST_D_GO:    state_next = ST_D_WAIT;
            ST_D_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (dcnt_reg + 3'd1 == kdiv) ? ST_C_STORE : ST_D_GO;
                end
            end
            ST_C_STORE: state_next = (idx_reg == 2'd2) ? ST_PUSH : ST_M1_GO;
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = second_reg ? ST_M1_GO : ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_S1_GO, ST_S2_GO, ST_D_GO: div_start = 1'b1;
            ST_M1_GO, ST_M2_GO:          mul_start = 1'b1;
            ST_PUSH:  load_out  = out_free;
            default:  in_ready  = 1'b0;
        endcase
    end

    qsc_serial_mul #(.NW(NUM_W), .TW(TIME_W)) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_m),
        .multiplier   (e_tr_reg),
        .done         (mul_done),
        .product      (mul_p)
    );

    qsc_serial_div #(.DW(DVD_W), .TW(TIME_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sv_reg     <= '0;
            sa_reg     <= '0;
            ev_reg     <= '0;
            ea_reg     <= '0;
            lim_reg    <= '1;
            older_reg  <= '0;
            newer_reg  <= '0;
            pvel_reg   <= '0;
            pdur_reg   <= '0;
            ps_reg     <= 2'd0;
            first_reg  <= 1'b1;
            second_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_VEL: sv_reg  <= cfg_data;
                    CFG_START_ACC: sa_reg  <= cfg_data;
                    CFG_END_VEL:   ev_reg  <= cfg_data;
                    CFG_END_ACC:   ea_reg  <= cfg_data;
                    CFG_VEL_LIM:   lim_reg <= cfg_data[LIM_W-1:0];
                    default:       lim_reg <= lim_reg;
                endcase
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_DECIDE:
                begin
                    case (ps_reg)
                        2'd0:
                        begin
                            newer_reg <= pin_reg;
                            pvel_reg  <= sv_reg;
                            first_reg <= 1'b1;
                            ps_reg    <= last_reg ? 2'd0 : 2'd1;
                        end
                        2'd1:
                        begin
                            if (last_reg)
                            begin
                                ps_reg    <= 2'd0;
                                first_reg <= 1'b1;
                            end
                            else
                            begin
                                older_reg <= newer_reg;
                                newer_reg <= pin_reg;
                                pdur_reg  <= tr_reg;
                                ps_reg    <= 2'd2;
                            end
                        end
                        default: ps_reg <= ps_reg;
                    endcase
                end
                ST_MEAN:
                begin
                    if (last_reg)
                    begin
                        ps_reg     <= 2'd0;
                        first_reg  <= 1'b1;
                        second_reg <= 1'b1;
                    end
                    else
                    begin
                        older_reg <= newer_reg;
                        newer_reg <= pin_reg;
                        pdur_reg  <= tr_reg;
                        pvel_reg  <= v_clamp[POS_W-1:0];
                        first_reg <= 1'b0;
                    end
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        second_reg <= 1'b0;
                    end
                end
                default: second_reg <= second_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            pin_reg  <= s_axis_tdata[31:0];
            tr_reg   <= tr_in;
            last_reg <= s_axis_tlast;
        end
        if (load_out)
        begin
            if (err_reg)
            begin
                odata_reg <= '0;
                ouser_reg <= STATUS_FEW;
                olast_reg <= 1'b1;
            end
            else
            begin
                odata_reg <= {e_tr_reg, cf_reg[2], cf_reg[1], cf_reg[0], c2, c1, c0};
                ouser_reg <= sat_reg ? STATUS_SAT : STATUS_OK;
                olast_reg <= e_fin_reg;
            end
        end
        case (state_reg)
            ST_DECIDE:
            begin
                err_reg  <= (ps_reg == 2'd0);
                num_reg  <= {{(DVD_W-POS_W-17){1'b0}}, d1_mag, 16'b0};
                den_reg  <= pdur_reg;
                neg_reg  <= d1[POS_W];
                e_p0_reg <= newer_reg;
                e_pf_reg <= pin_reg;
                e_v0_reg <= pvel_reg;
                e_a0_reg <= first_reg ? sa_reg : '0;
                e_vf_reg <= ev_reg;
                e_af_reg <= ea_reg;
                e_tr_reg <= tr_reg;
                e_fin_reg <= 1'b1;
                sat_reg  <= 1'b0;
                idx_reg  <= 2'd0;
                dcnt_reg <= 3'd0;
            end
            ST_S1_WAIT:
            begin
                if (div_done)
                begin
                    s1_reg  <= neg_reg ? -$signed({2'b00, div_q[48:0]})
                                       : $signed({2'b00, div_q[48:0]});
                    num_reg <= {{(DVD_W-POS_W-17){1'b0}}, d2_mag, 16'b0};
                    den_reg <= tr_reg;
                    neg_reg <= d2[POS_W];
                end
            end
            ST_MEAN:
            begin
                v_reg     <= v_clamp[POS_W-1:0];
                err_reg   <= 1'b0;
                e_p0_reg  <= older_reg;
                e_pf_reg  <= newer_reg;
                e_v0_reg  <= pvel_reg;
                e_a0_reg  <= first_reg ? sa_reg : '0;
                e_vf_reg  <= v_clamp[POS_W-1:0];
                e_af_reg  <= '0;
                e_tr_reg  <= pdur_reg;
                e_fin_reg <= 1'b0;
                sat_reg   <= 1'b0;
                idx_reg   <= 2'd0;
                dcnt_reg  <= 3'd0;
            end
            ST_M2_WAIT:
            begin
                if (mul_done)
                begin
                    neg_reg  <= n_full[NUM_W-1];
                    num_reg  <= nshift;
                    den_reg  <= e_tr_reg;
                    dcnt_reg <= 3'd0;
                end
            end
            ST_D_WAIT:
            begin
                if (div_done)
                begin
                    num_reg  <= div_q;
                    dcnt_reg <= dcnt_reg + 3'd1;
                end
            end
            ST_C_STORE:
            begin
                cf_reg[idx_reg] <= c_val;
                sat_reg         <= sat_reg | c_sat;
                idx_reg         <= idx_reg + 2'd1;
            end
            ST_PUSH:
            begin
                if (out_free && second_reg)
                begin
                    err_reg   <= 1'b0;
                    e_p0_reg  <= newer_reg;
                    e_pf_reg  <= pin_reg;
                    e_v0_reg  <= v_reg;
                    e_a0_reg  <= '0;
                    e_vf_reg  <= ev_reg;
                    e_af_reg  <= ea_reg;
                    e_tr_reg  <= tr_reg;
                    e_fin_reg <= 1'b1;
                    sat_reg   <= 1'b0;
                    idx_reg   <= 2'd0;
                    dcnt_reg  <= 3'd0;
                end
            end
            default: dcnt_reg <= dcnt_reg;
        endcase
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

FILE: rtl/core/qsc_checker.sv
// Port-level checker for the quintic segment coefficients unit, bound to the top level.
// Depends on qsc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "quintic_segment_coefficients_unit_macros.svh"

module qsc_checker
    import qsc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [311:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic [1:0]   m_axis_tuser
);

    // A stalled result beat stays offered.
    `QSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // The lone waypoint result always closes the path and carries no coefficients.
    `QSC_ASSERT_IMPLIES(a_few_last, m_axis_tvalid && (m_axis_tuser == STATUS_FEW), m_axis_tlast)
    `QSC_ASSERT_IMPLIES(a_few_zero, m_axis_tvalid && (m_axis_tuser == STATUS_FEW),
                        m_axis_tdata == '0)

    // Real segments never report a zero duration.
    `QSC_ASSERT_IMPLIES(a_dur_nonzero, m_axis_tvalid && (m_axis_tuser != STATUS_FEW),
                        m_axis_tdata[311:288] != '0)

endmodule

bind quintic_segment_coefficients_unit qsc_checker u_qsc_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the quintic segment coefficients unit: waypoint paths go in
// as stream beats, and every segment beat is checked against a built-in fixed-point predictor.
// Depends on qsc_pkg and the quintic_segment_coefficients_unit RTL.
`timescale 1ns / 1ps

module tb_top;
    import qsc_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [5:0][COEF_W-1:0] c;
        logic [TIME_W-1:0]      dur;
        logic                   fin;
        logic [1:0]             status;
    } segment_t;

    class segment_scoreboard;
        segment_t   expected_segments[$];
        int         errors;
        int         checked;
        longint     start_vel, start_acc, end_vel, end_acc, vel_limit;
        longint     older_pos, newer_pos, pend_vel;
        longint     pend_dur;
        int         points;
        bit         pend_first;

        function new();
            start_vel  = 0;
            start_acc  = 0;
            end_vel    = 0;
            end_acc    = 0;
            vel_limit  = 64'h7fffffff;
            older_pos  = 0;
            newer_pos  = 0;
            pend_vel   = 0;
            pend_dur   = 0;
            points     = 0;
            pend_first = 1;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_START_VEL: start_vel = longint'($signed(val));
                CFG_START_ACC: start_acc = longint'($signed(val));
                CFG_END_VEL:   end_vel   = longint'($signed(val));
                CFG_END_ACC:   end_acc   = longint'($signed(val));
                CFG_VEL_LIM:   vel_limit = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        function wide_t numerator(longint h, longint v0, longint vf, longint a0, longint af,
                                  longint tr, int kh, int kvf, int kv0, int ka0, int kaf);
            wide_t n;
            n = wide_t'(h * kh) <<< 32;
            n = n + ((wide_t'(vf * kvf + v0 * kv0) * wide_t'(tr)) <<< 16);
            n = n + wide_t'(a0 * ka0 + af * kaf) * wide_t'(tr) * wide_t'(tr);
            return n;
        endfunction

        function logic [COEF_W-1:0] scaled_quotient(wide_t n, int shift, longint tr, int k,
                                                    inout bit sat);
            wide_t d;
            wide_t q;
            wide_t hi;
            wide_t lo;
            d = 1;
            for (int i = 0; i < k; i++)
                d = d * wide_t'(tr);
            q  = (n <<< shift) / d;
            hi = (wide_t'(1) <<< 47) - 1;
            lo = -(wide_t'(1) <<< 47);
            if (q > hi)
            begin
                q = hi;
                sat = 1;
            end
            else if (q < lo)
            begin
                q = lo;
                sat = 1;
            end
            return q[COEF_W-1:0];
        endfunction

        function segment_t solve_segment(longint p0, longint pf, longint v0, longint a0,
                                         longint vf, longint af, longint tr, bit fin);
            segment_t s;
            bit       sat;
            longint   h;
            longint   t;
            sat = 0;
            h = pf - p0;
            t = p0 * 65536;
            s.c[0] = t[COEF_W-1:0];
            t = v0 * 65536;
            s.c[1] = t[COEF_W-1:0];
            t = a0 * 32768;
            s.c[2] = t[COEF_W-1:0];
            s.c[3] = scaled_quotient(numerator(h, v0, vf, a0, af, tr, 20, -8, -12, -3, 1),
                                     31, tr, 3, sat);
            s.c[4] = scaled_quotient(numerator(h, v0, vf, a0, af, tr, -30, 14, 16, 3, -2),
                                     47, tr, 4, sat);
            s.c[5] = scaled_quotient(numerator(h, v0, vf, a0, af, tr, 12, -6, -6, -1, 1),
                                     63, tr, 5, sat);
            s.dur    = tr[TIME_W-1:0];
            s.fin    = fin;
            s.status = sat ? STATUS_SAT : STATUS_OK;
            return s;
        endfunction

        function longint slope(longint d, longint tr);
            return (d * 65536) / tr;
        endfunction

        function void note_input(logic [31:0] pos_bits, logic [TIME_W-1:0] t_bits, bit last);
            longint   p;
            longint   tr;
            longint   a0;
            longint   v;
            segment_t s;
            p  = longint'($signed(pos_bits));
            tr = (t_bits == 0) ? 1 : longint'(t_bits);
            if (points == 0)
            begin
                newer_pos  = p;
                pend_vel   = start_vel;
                pend_first = 1;
                if (last)
                begin
                    s.c      = '0;
                    s.dur    = '0;
                    s.fin    = 1;
                    s.status = STATUS_FEW;
                    expected_segments.insert(expected_segments.size(), s);
                end
                else
                    points = 1;
                return;
            end
            a0 = pend_first ? start_acc : 0;
            if (points == 1)
            begin
                if (last)
                begin
                    expected_segments.insert(expected_segments.size(),
                        solve_segment(newer_pos, p, pend_vel, a0, end_vel, end_acc, tr, 1));
                    points     = 0;
                    pend_first = 1;
                end
                else
                begin
                    older_pos = newer_pos;
                    newer_pos = p;
                    pend_dur  = tr;
                    points    = 2;
                end
                return;
            end
            v = (slope(newer_pos - older_pos, pend_dur) + slope(p - newer_pos, tr)) / 2;
            if (v > vel_limit)
                v = vel_limit;
            if (v < -vel_limit)
                v = -vel_limit;
            expected_segments.insert(expected_segments.size(),
                solve_segment(older_pos, newer_pos, pend_vel, a0, v, 0, pend_dur, 0));
            if (last)
            begin
                expected_segments.insert(expected_segments.size(),
                    solve_segment(newer_pos, p, v, 0, end_vel, end_acc, tr, 1));
                points     = 0;
                pend_first = 1;
            end
            else
            begin
                older_pos  = newer_pos;
                newer_pos  = p;
                pend_dur   = tr;
                pend_vel   = v;
                pend_first = 0;
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        endtask

        task check_segment(logic [311:0] data, logic last, logic [1:0] user);
            segment_t s;
            checked++;
            if (expected_segments.size() == 0)
            begin
                report("unexpected beat", data[63:0], 64'd0);
                return;
            end
            s = expected_segments.pop_front();
            for (int j = 0; j < 6; j++)
                if (data[48*j +: 48] !== s.c[j])
                    report($sformatf("coef_%0d", j), 64'(data[48*j +: 48]), 64'(s.c[j]));
            if (data[311:288] !== s.dur)
                report("duration", 64'(data[311:288]), 64'(s.dur));
            if (last !== s.fin)
                report("final_segment", 64'(last), 64'(s.fin));
            if (user !== s.status)
                report("status", 64'(user), 64'(s.status));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [55:0]        s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [311:0]       m_axis_tdata;
    logic               m_axis_tlast;
    logic [1:0]         m_axis_tuser;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [POS_W-1:0]   cfg_data;

    segment_scoreboard  sb;
    bit                 quiet;
    int                 stall_left;
    int                 idle_cycles;
    int                 waypoints_sent;
    int                 paths_sent;

    quintic_segment_coefficients_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 0;
            stall_left <= $urandom_range(0, 3);
        end
        else
            m_axis_tready <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_segment(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    task send_waypoint(logic [31:0] pos, logic [TIME_W-1:0] t, bit last);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tdata  = {t, pos};
        s_axis_tlast  = last;
        s_axis_tvalid = 1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(pos, t, last);
        waypoints_sent++;
        if (last)
            paths_sent++;
        @(negedge clk);
    endtask

    task drain();
        s_axis_tvalid = 0;
        while (sb.expected_segments.size() > 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    function logic [31:0] pick_position();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
        endcase
    endfunction

    function logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 11))
            0: return 24'd0;
            1: return 24'hffffff;
            2, 3, 4: return 24'($urandom);
            default: return 24'($urandom_range(1, 24'h3ffff));
        endcase
    endfunction

    task random_paths(int count);
        int n;
        int len;
        n = 0;
        while (n < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
            for (int i = 0; i < len; i++)
                send_waypoint(pick_position(), pick_time(), i == len - 1);
            n += len;
        end
    endtask

    initial
    begin
        clk            = 0;
        sb             = new();
        rst_n          = 0;
        s_axis_tvalid  = 0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 0;
        m_axis_tready  = 0;
        cfg_we         = 0;
        cfg_index      = CFG_START_VEL;
        cfg_data       = '0;
        quiet          = 0;
        stall_left     = 0;
        idle_cycles    = 0;
        waypoints_sent = 0;
        paths_sent     = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_waypoint(32'h00010000, 24'h010000, 1);
        send_waypoint(32'h7fffffff, 24'h000000, 0);
        send_waypoint(32'h80000000, 24'h000001, 1);
        send_waypoint(32'h80000000, 24'h123456, 0);
        send_waypoint(32'h7fffffff, 24'hffffff, 0);
        send_waypoint(32'h00000000, 24'h010000, 1);
        send_waypoint(32'h00000000, 24'h010000, 0);
        send_waypoint(32'h00020000, 24'h010000, 0);
        send_waypoint(32'h00030000, 24'h008000, 0);
        send_waypoint(32'hfffe0000, 24'h000000, 1);
        drain();

        write_reg(CFG_START_VEL, 32'h7fffffff);
        write_reg(CFG_START_ACC, 32'h7fffffff);
        write_reg(CFG_END_VEL,   32'h7fffffff);
        write_reg(CFG_END_ACC,   32'h7fffffff);
        write_reg(CFG_VEL_LIM,   32'h7fffffff);
        send_waypoint(32'h00000000, 24'h000000, 0);
        send_waypoint(32'h7fffffff, 24'h000001, 1);
        send_waypoint(32'h80000000, 24'h000000, 0);
        send_waypoint(32'h7fffffff, 24'hffffff, 0);
        send_waypoint(32'h80000000, 24'h000001, 1);
        random_paths(250);
        drain();

        write_reg(CFG_START_VEL, 32'h80000000);
        write_reg(CFG_START_ACC, 32'h80000000);
        write_reg(CFG_END_VEL,   32'h80000000);
        write_reg(CFG_END_ACC,   32'h80000000);
        write_reg(CFG_VEL_LIM,   32'h00000000);
        send_waypoint(32'h12345678, 24'h000100, 0);
        send_waypoint(32'hedcba987, 24'h000100, 0);
        send_waypoint(32'h12345678, 24'h000100, 1);
        random_paths(120);
        drain();
        random_paths(190);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(CFG_START_VEL, (ph == 0) ? $urandom : 32'($urandom_range(0, 65536 * 8)));
            write_reg(CFG_START_ACC, $urandom);
            write_reg(CFG_END_VEL,   $urandom);
            write_reg(CFG_END_ACC,   $urandom);
            write_reg(CFG_VEL_LIM,   (ph == 1) ? 32'($urandom_range(0, 65536 * 4)) : $urandom);
            if (ph == 2)
                quiet = 1;
            random_paths(250);
            drain();
        end

        $display("Covered %0d waypoints in %0d paths over several register settings.",
                 waypoints_sent, paths_sent);
        $display("Checked %0d segment beats; %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_segments.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
